/* rtl/aesinv_pkg.sv */
// Shared types, codes and GF(2^8) helpers for the AES inverse cipher block.
package aesinv_pkg;

   localparam int WORD_W  = 6;
   localparam int ROUND_W = 4;
   localparam int STEP_W  = 5;
   localparam int PHASE_W = 3;
   localparam int CSR_W   = 3;

   localparam logic [CSR_W-1:0] CSR_KEY_SIZE   = 3'd0;
   localparam logic [CSR_W-1:0] CSR_KEY_PART_0 = 3'd1;
   localparam logic [CSR_W-1:0] CSR_KEY_PART_1 = 3'd2;
   localparam logic [CSR_W-1:0] CSR_KEY_PART_2 = 3'd3;
   localparam logic [CSR_W-1:0] CSR_KEY_PART_3 = 3'd4;

   localparam logic FUNC_LOAD    = 1'b0;
   localparam logic FUNC_DECRYPT = 1'b1;

   localparam logic [1:0] KEY_128 = 2'd0;
   localparam logic [1:0] KEY_192 = 2'd1;

   localparam logic [7:0] RCON_FIRST = 8'h01;
   localparam logic [7:0] GF_POLY    = 8'h1B;

   typedef struct packed {
      logic        func;
      logic [7:0]  sbox_index;
      logic [7:0]  sbox_value;
      logic [63:0] cipher_high;
      logic [63:0] cipher_low;
   } req_type;

   typedef struct packed {
      logic [63:0] plain_high;
      logic [63:0] plain_low;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_KEY_INIT,
      ST_KX_START,
      ST_KX_SUB,
      ST_KX_WRITE,
      ST_ARK,
      ST_COPY,
      ST_PERM,
      ST_SUB,
      ST_MIX,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      T_PLAIN,
      T_SUB,
      T_SUB_RCON
   } tsel_type;

   typedef struct packed {
      logic              sbox_we;
      logic              cipher_load;
      logic              rk_we;
      logic              rk_key_word;
      logic [WORD_W-1:0] word_idx;
      logic              kw_load;
      logic              kw_rot;
      logic              fsb_issue;
      tsel_type          t_sel;
      logic              rcon_init;
      logic              rcon_step;
      logic              rk_issue;
      logic [WORD_W-1:0] rk_addr;
      logic              acc_to_state;
      logic              perm;
      logic              isb_issue;
      logic              mix;
      logic              out_load;
   } cmd_type;

   typedef struct packed {
      logic [1:0] key_size;
   } status_type;

   function automatic logic [7:0] xtime(input logic [7:0] b);
      return b[7] ? ({b[6:0], 1'b0} ^ GF_POLY) : {b[6:0], 1'b0};
   endfunction

   function automatic logic [31:0] inv_mix_col(input logic [31:0] w);
      logic [7:0] a [4];
      logic [7:0] x2 [4];
      logic [7:0] x4 [4];
      logic [7:0] x8 [4];
      logic [7:0] m9 [4];
      logic [7:0] mb [4];
      logic [7:0] md [4];
      logic [7:0] me [4];
      for (int r = 0; r < 4; r++) begin
         a[r]  = w[31-8*r -: 8];
         x2[r] = xtime(a[r]);
         x4[r] = xtime(x2[r]);
         x8[r] = xtime(x4[r]);
         m9[r] = x8[r] ^ a[r];
         mb[r] = x8[r] ^ x2[r] ^ a[r];
         md[r] = x8[r] ^ x4[r] ^ a[r];
         me[r] = x8[r] ^ x4[r] ^ x2[r];
      end
      return {me[0] ^ mb[1] ^ md[2] ^ m9[3],
              m9[0] ^ me[1] ^ mb[2] ^ md[3],
              md[0] ^ m9[1] ^ me[2] ^ mb[3],
              mb[0] ^ md[1] ^ m9[2] ^ me[3]};
   endfunction

   function automatic logic [127:0] inv_mix(input logic [127:0] s);
      logic [127:0] t;
      for (int c = 0; c < 4; c++) begin
         t[127-32*c -: 32] = inv_mix_col(s[127-32*c -: 32]);
      end
      return t;
   endfunction

   function automatic logic [127:0] inv_shift(input logic [127:0] s);
      logic [127:0] t;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[127-8*(c*4+r) -: 8] = s[127-8*((((c+4-r)%4)*4)+r) -: 8];
         end
      end
      return t;
   endfunction

endpackage

/* rtl/aesinv_dp.sv */
// Datapath: configuration, S-box and round key memories, key schedule and round state.
module aesinv_dp import aesinv_pkg::*; #(
   parameter int ROUND_KEY_WORDS = 60
) (
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   output status_type       status,
   input  req_type          req_data,
   output rsp_type          rsp_data,
   input  logic             csr_we,
   input  logic [CSR_W-1:0] csr_index,
   input  logic [63:0]      csr_wdata
);

   localparam int AW = $clog2(ROUND_KEY_WORDS);
   localparam logic [WORD_W-1:0] RK_LIMIT = WORD_W'(ROUND_KEY_WORDS);

   logic [7:0]        fwd_mem [256];
   logic [7:0]        inv_mem [256];
   logic [31:0]       rk_mem  [ROUND_KEY_WORDS];

   logic [1:0]        key_size_ff;
   logic [63:0]       key_part_ff [4];
   logic [7:0][31:0]  win_ff;
   logic [31:0]       kw_ff;
   logic [31:0]       sw_ff;
   logic [7:0]        rcon_ff;
   logic [7:0]        fsb_rdata_ff;
   logic [7:0]        isb_rdata_ff;
   logic [31:0]       rk_rdata_ff;
   logic              rk_oob_ff;
   logic              fsb_vld_ff;
   logic              isb_vld_ff;
   logic              rk_vld_ff;
   logic [127:0]      acc_ff;
   logic [127:0]      state_ff;
   logic [127:0]      out_ff;

   logic [2:0]        tap;
   logic [31:0]       t_word;
   logic [31:0]       key_word;
   logic [31:0]       new_word;
   logic [31:0]       push_word;
   logic              wr_in_range;
   logic [31:0]       rk_word;

   assign status.key_size = key_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_size_ff <= KEY_128;
         for (int j = 0; j < 4; j++) begin
            key_part_ff[j] <= '0;
         end
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_KEY_SIZE:   key_size_ff    <= csr_wdata[1:0];
            CSR_KEY_PART_0: key_part_ff[0] <= csr_wdata;
            CSR_KEY_PART_1: key_part_ff[1] <= csr_wdata;
            CSR_KEY_PART_2: key_part_ff[2] <= csr_wdata;
            CSR_KEY_PART_3: key_part_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (key_size_ff)
         KEY_128: tap = 3'd3;
         KEY_192: tap = 3'd5;
         default: tap = 3'd7;
      endcase
      unique case (cmd.t_sel)
         T_SUB:      t_word = sw_ff;
         T_SUB_RCON: t_word = sw_ff ^ {rcon_ff, 24'h000000};
         default:    t_word = win_ff[0];
      endcase
      key_word = cmd.word_idx[0] ? key_part_ff[cmd.word_idx[2:1]][31:0]
                                 : key_part_ff[cmd.word_idx[2:1]][63:32];
      new_word    = cmd.rk_key_word ? key_word : (win_ff[tap] ^ t_word);
      wr_in_range = cmd.word_idx < RK_LIMIT;
      push_word   = wr_in_range ? new_word : 32'h0;
      rk_word     = rk_oob_ff ? 32'h0 : rk_rdata_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.sbox_we) begin
         fwd_mem[req_data.sbox_index] <= req_data.sbox_value;
         inv_mem[req_data.sbox_value] <= req_data.sbox_index;
      end
      fsb_rdata_ff <= fwd_mem[kw_ff[31:24]];
      isb_rdata_ff <= inv_mem[state_ff[127:120]];
   end

   always_ff @(posedge clock) begin
      if (cmd.rk_we && wr_in_range) begin
         rk_mem[cmd.word_idx[AW-1:0]] <= new_word;
      end
      rk_rdata_ff <= rk_mem[cmd.rk_addr[AW-1:0]];
      rk_oob_ff   <= !(cmd.rk_addr < RK_LIMIT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsb_vld_ff <= 1'b0;
         isb_vld_ff <= 1'b0;
         rk_vld_ff  <= 1'b0;
      end else begin
         fsb_vld_ff <= cmd.fsb_issue;
         isb_vld_ff <= cmd.isb_issue;
         rk_vld_ff  <= cmd.rk_issue;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rk_we) begin
         win_ff <= {win_ff[6:0], push_word};
      end
      if (cmd.kw_load) begin
         kw_ff <= cmd.kw_rot ? {win_ff[0][23:0], win_ff[0][31:24]} : win_ff[0];
      end else if (cmd.fsb_issue) begin
         kw_ff <= {kw_ff[23:0], 8'h00};
      end
      if (fsb_vld_ff) begin
         sw_ff <= {sw_ff[23:0], fsb_rdata_ff};
      end
      if (cmd.rcon_init) begin
         rcon_ff <= RCON_FIRST;
      end else if (cmd.rcon_step) begin
         rcon_ff <= xtime(rcon_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cipher_load) begin
         acc_ff <= {req_data.cipher_high, req_data.cipher_low};
      end else if (rk_vld_ff) begin
         acc_ff <= {acc_ff[95:0], acc_ff[127:96] ^ rk_word};
      end else if (isb_vld_ff) begin
         acc_ff <= {acc_ff[119:0], isb_rdata_ff};
      end
      if (cmd.acc_to_state) begin
         state_ff <= acc_ff;
      end else if (cmd.perm) begin
         state_ff <= inv_shift(state_ff);
      end else if (cmd.isb_issue) begin
         state_ff <= {state_ff[119:0], 8'h00};
      end else if (cmd.mix) begin
         state_ff <= inv_mix(acc_ff);
      end
      if (cmd.out_load) begin
         out_ff <= acc_ff;
      end
   end

   assign rsp_data.plain_high = out_ff[127:64];
   assign rsp_data.plain_low  = out_ff[63:0];

endmodule

/* rtl/aesinv_ctrl.sv */
// Controller: sequences S-box loads, key expansion and decryption rounds.
module aesinv_ctrl import aesinv_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_func,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type          state_ff, state_in;
   logic [WORD_W-1:0]  word_ff, word_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [ROUND_W-1:0] round_ff, round_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               first_ff, first_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [WORD_W-1:0]  nk;
   logic [ROUND_W-1:0] nr;
   logic [WORD_W-1:0]  last_word;
   logic               nk8;
   logic               accept;
   logic               sub_rcon;
   logic               sub_plain;
   logic               out_free;

   always_comb begin
      unique case (status.key_size)
         KEY_128: begin
            nk        = 6'd4;
            nr        = 4'd10;
            last_word = 6'd43;
         end
         KEY_192: begin
            nk        = 6'd6;
            nr        = 4'd12;
            last_word = 6'd51;
         end
         default: begin
            nk        = 6'd8;
            nr        = 4'd14;
            last_word = 6'd59;
         end
      endcase
      nk8       = nk == 6'd8;
      sub_rcon  = phase_ff == 3'd0;
      sub_plain = nk8 && (phase_ff == 3'd4);
   end

   assign req_stall = state_ff != ST_IDLE;
   assign accept    = req_valid && !req_stall;
   assign out_free  = !(rsp_valid_ff && rsp_stall);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_func == FUNC_DECRYPT) state_in = ST_KEY_INIT;
         end
         ST_KEY_INIT: begin
            if (word_ff == nk - 6'd1) state_in = ST_KX_START;
         end
         ST_KX_START: begin
            state_in = (sub_rcon || sub_plain) ? ST_KX_SUB : ST_KX_WRITE;
         end
         ST_KX_SUB: begin
            if (step_ff == 5'd4) state_in = ST_KX_WRITE;
         end
         ST_KX_WRITE: begin
            state_in = (word_ff == last_word) ? ST_ARK : ST_KX_START;
         end
         ST_ARK: begin
            if (step_ff == 5'd4) begin
               priority if (first_ff) state_in = ST_COPY;
               else if (round_ff == '0) state_in = ST_FINISH;
               else state_in = ST_MIX;
            end
         end
         ST_COPY:   state_in = ST_PERM;
         ST_PERM:   state_in = ST_SUB;
         ST_SUB: begin
            if (step_ff == 5'd16) state_in = ST_ARK;
         end
         ST_MIX:    state_in = ST_PERM;
         ST_FINISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd              = '0;
      cmd.t_sel        = T_PLAIN;
      cmd.word_idx     = word_ff;
      cmd.rk_addr      = {round_ff, step_ff[1:0]};
      cmd.sbox_we      = accept && req_func == FUNC_LOAD;
      cmd.cipher_load  = accept && req_func == FUNC_DECRYPT;
      cmd.rcon_init    = cmd.cipher_load;
      unique case (state_ff)
         ST_KEY_INIT: begin
            cmd.rk_we       = 1'b1;
            cmd.rk_key_word = 1'b1;
         end
         ST_KX_START: begin
            cmd.kw_load = sub_rcon || sub_plain;
            cmd.kw_rot  = sub_rcon;
         end
         ST_KX_SUB:   cmd.fsb_issue = step_ff < 5'd4;
         ST_KX_WRITE: begin
            cmd.rk_we     = 1'b1;
            cmd.rcon_step = sub_rcon;
            priority if (sub_rcon) cmd.t_sel = T_SUB_RCON;
            else if (sub_plain) cmd.t_sel = T_SUB;
            else cmd.t_sel = T_PLAIN;
         end
         ST_ARK:      cmd.rk_issue     = step_ff < 5'd4;
         ST_COPY:     cmd.acc_to_state = 1'b1;
         ST_PERM:     cmd.perm         = 1'b1;
         ST_SUB:      cmd.isb_issue    = step_ff < 5'd16;
         ST_MIX:      cmd.mix          = 1'b1;
         ST_FINISH:   cmd.out_load     = out_free;
         default: ;
      endcase
   end

   always_comb begin
      word_in      = word_ff;
      phase_in     = phase_ff;
      round_in     = round_ff;
      first_in     = first_ff;
      step_in      = (state_in != state_ff) ? '0 : step_ff + 5'd1;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (cmd.out_load) rsp_valid_in = 1'b1;
      unique case (state_ff)
         ST_IDLE:     word_in = '0;
         ST_KEY_INIT: begin
            word_in  = word_ff + 6'd1;
            phase_in = '0;
         end
         ST_KX_WRITE: begin
            word_in  = word_ff + 6'd1;
            phase_in = (phase_ff == PHASE_W'(nk - 6'd1)) ? '0 : phase_ff + 3'd1;
            round_in = nr;
            first_in = 1'b1;
         end
         ST_COPY: begin
            first_in = 1'b0;
            round_in = nr - 4'd1;
         end
         ST_MIX:      round_in = round_ff - 4'd1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         word_ff      <= '0;
         phase_ff     <= '0;
         round_ff     <= '0;
         step_ff      <= '0;
         first_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         word_ff      <= word_in;
         phase_ff     <= phase_in;
         round_ff     <= round_in;
         step_ff      <= step_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* rtl/aes_inverse_cipher_loadable_sbox.sv */
// Top level of the AES inverse cipher with a loadable S-box.
// Usage:
//   req channel (req_valid, req_stall, req_data) carries one transaction per item.
//   func load writes one forward S-box entry and, in the same cycle, the matching
//   inverse entry and returns nothing. func decrypt returns one rsp transaction.
//   csr port writes key_size and the four 64-bit key parts. The user must write
//   them only while the block is idle; the block itself leaves this to the user.
// A decrypt expands the key schedule with the loaded S-box; a word that needs
//   SubWord takes four S-box reads through the one forward S-box port. Each round
//   then takes 16 reads of the single inverse S-box port and 4 round key reads.
//   The block takes no new transaction while a decrypt is in progress, up to the
//   loading of its result into the output register.
// Reset clears the configuration and control state; S-box contents are kept
//   undefined until loaded.
// A result waits in the output register while rsp_stall is high; the block
//   still accepts and processes the next transaction, holding its own result
//   back only until the earlier one has been taken.
module aes_inverse_cipher_loadable_sbox import aesinv_pkg::*; #(
   parameter int ROUND_KEY_WORDS = 60
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   input  logic             csr_we,
   input  logic [CSR_W-1:0] csr_index,
   input  logic [63:0]      csr_wdata
);

   cmd_type    cmd;
   status_type status;

   aesinv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_func  (req_data.func),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   aesinv_dp #(
      .ROUND_KEY_WORDS (ROUND_KEY_WORDS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

endmodule

/* tb/tb_aes_inverse_cipher_loadable_sbox.sv */
// Self-checking testbench for the AES inverse cipher with a loadable S-box.
module tb_aes_inverse_cipher_loadable_sbox;
   import aesinv_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_we;
   logic [CSR_W-1:0] csr_index;
   logic [63:0] csr_wdata;

   logic [7:0]  fwd_tab [256];
   logic [7:0]  inv_tab [256];
   logic [1:0]  key_size_q;
   logic [63:0] key_q [4];

   rsp_type     plain_q [$];
   int          errors;
   int          n_loads;
   int          n_decrypts;
   int          n_checked;
   int          idle_pct;
   int          stall_pct;
   int          hold_cycles;

   aes_inverse_cipher_loadable_sbox uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] acc;
      acc = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (a[i]) acc = acc ^ b;
         b = b[7] ? ({b[6:0], 1'b0} ^ 8'h1B) : {b[6:0], 1'b0};
      end
      return acc;
   endfunction

   function automatic logic [31:0] sub_word32(input logic [31:0] w);
      return {fwd_tab[w[31:24]], fwd_tab[w[23:16]], fwd_tab[w[15:8]], fwd_tab[w[7:0]]};
   endfunction

   function automatic req_type rand_req();
      logic [159:0] v;
      v = {$urandom, $urandom, $urandom, $urandom, $urandom};
      return v[$bits(req_type)-1:0];
   endfunction

   function automatic rsp_type decrypt_block(input logic [63:0] hi, input logic [63:0] lo);
      logic [7:0]  rcon [10];
      logic [31:0] w [60];
      logic [7:0]  s [16];
      logic [7:0]  t [16];
      logic [7:0]  a [4];
      logic [31:0] tw;
      logic [127:0] ct;
      logic [127:0] pt;
      int nk;
      int nr;
      int k;
      rsp_type r;
      rcon = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1B, 8'h36};
      nk = (key_size_q == KEY_128) ? 4 : (key_size_q == KEY_192) ? 6 : 8;
      nr = nk + 6;
      for (int i = 0; i < nk; i++) begin
         tw = 32'h0;
         for (int j = 0; j < 4; j++) begin
            k = 4 * i + j;
            tw = {tw[23:0], key_q[(k >> 3) & 3][63 - 8 * (k & 7) -: 8]};
         end
         w[i] = tw;
      end
      for (int i = nk; i < 4 * (nr + 1); i++) begin
         tw = w[i - 1];
         if (i % nk == 0)
            tw = sub_word32({tw[23:0], tw[31:24]}) ^ {rcon[i / nk - 1], 24'h0};
         else if (nk > 6 && i % nk == 4)
            tw = sub_word32(tw);
         w[i] = w[i - nk] ^ tw;
      end
      ct = {hi, lo};
      for (int b = 0; b < 16; b++) s[b] = ct[127 - 8 * b -: 8];
      for (int rd = nr; rd >= 0; rd--) begin
         if (rd != nr) begin
            for (int c = 0; c < 4; c++)
               for (int q = 0; q < 4; q++)
                  t[c * 4 + q] = inv_tab[s[((c + 4 - q) % 4) * 4 + q]];
            s = t;
         end
         for (int c = 0; c < 4; c++)
            for (int q = 0; q < 4; q++)
               s[c * 4 + q] = s[c * 4 + q] ^ w[rd * 4 + c][31 - 8 * q -: 8];
         if (rd != nr && rd != 0) begin
            for (int c = 0; c < 4; c++) begin
               for (int q = 0; q < 4; q++) a[q] = s[c * 4 + q];
               s[c*4]   = gmul(8'h0E,a[0]) ^ gmul(8'h0B,a[1]) ^ gmul(8'h0D,a[2]) ^ gmul(8'h09,a[3]);
               s[c*4+1] = gmul(8'h09,a[0]) ^ gmul(8'h0E,a[1]) ^ gmul(8'h0B,a[2]) ^ gmul(8'h0D,a[3]);
               s[c*4+2] = gmul(8'h0D,a[0]) ^ gmul(8'h09,a[1]) ^ gmul(8'h0E,a[2]) ^ gmul(8'h0B,a[3]);
               s[c*4+3] = gmul(8'h0B,a[0]) ^ gmul(8'h0D,a[1]) ^ gmul(8'h09,a[2]) ^ gmul(8'h0E,a[3]);
            end
         end
      end
      for (int b = 0; b < 16; b++) pt[127 - 8 * b -: 8] = s[b];
      r.plain_high = pt[127:64];
      r.plain_low  = pt[63:0];
      return r;
   endfunction

   // Called at a falling edge; returns at a falling edge.
   task automatic send_item(input req_type item);
      int gap;
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      if (item.func == FUNC_LOAD) begin
         fwd_tab[item.sbox_index] = item.sbox_value;
         inv_tab[item.sbox_value] = item.sbox_index;
         n_loads++;
      end else begin
         plain_q.push_back(decrypt_block(item.cipher_high, item.cipher_low));
         n_decrypts++;
      end
      @(negedge clock);
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         req_data  <= rand_req();
         gap = $urandom_range(1, 4);
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic send_load(input logic [7:0] idx, input logic [7:0] val);
      req_type item;
      item = rand_req();
      item.func       = FUNC_LOAD;
      item.sbox_index = idx;
      item.sbox_value = val;
      send_item(item);
   endtask

   task automatic send_decrypt(input logic [63:0] hi, input logic [63:0] lo);
      req_type item;
      item = rand_req();
      item.func        = FUNC_DECRYPT;
      item.cipher_high = hi;
      item.cipher_low  = lo;
      send_item(item);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (plain_q.size() != 0) @(negedge clock);
      repeat (600) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_W-1:0] idx, input logic [63:0] val);
      req_valid <= 1'b0;
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_KEY_SIZE) key_size_q = val[1:0];
      else key_q[idx - 1] = val;
   endtask

   task automatic set_key(input logic [1:0] ks, input logic [63:0] k0, input logic [63:0] k1,
                          input logic [63:0] k2, input logic [63:0] k3);
      write_csr(CSR_KEY_SIZE, {62'h0, ks});
      write_csr(CSR_KEY_PART_0, k0);
      write_csr(CSR_KEY_PART_1, k1);
      write_csr(CSR_KEY_PART_2, k2);
      write_csr(CSR_KEY_PART_3, k3);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic test_full_table_load();
      logic [7:0] perm [256];
      logic [7:0] tmp;
      int j;
      for (int i = 0; i < 256; i++) perm[i] = i[7:0];
      for (int i = 255; i > 0; i--) begin
         j = $urandom_range(i);
         tmp = perm[i];
         perm[i] = perm[j];
         perm[j] = tmp;
      end
      for (int i = 0; i < 256; i++) send_load(i[7:0], perm[i]);
   endtask

   task automatic test_directed_decrypt();
      for (int ks = 0; ks < 3; ks++) begin
         drain();
         set_key(ks[1:0], '0, '0, '0, '0);
         send_decrypt('0, '0);
         send_decrypt('1, '1);
         drain();
         set_key(ks[1:0], '1, '1, '1, '1);
         send_decrypt('0, '1);
         send_decrypt(64'h0123456789ABCDEF, 64'hFEDCBA9876543210);
      end
      send_load(8'h00, 8'hFF);
      send_load(8'hFF, 8'h00);
      send_load(8'hFF, 8'hFF);
      send_load(8'h00, 8'h00);
      send_decrypt(rand64(), rand64());
      drain();
   endtask

   task automatic test_random_traffic(input int n_items, input int idle, input int stall);
      idle_pct  = idle;
      stall_pct = stall;
      set_key(2'($urandom_range(2)), rand64(), rand64(), rand64(), rand64());
      for (int i = 0; i < n_items; i++) begin
         if ($urandom_range(99) < 60) send_load(8'($urandom), 8'($urandom));
         else send_decrypt(rand64(), rand64());
      end
      drain();
   endtask

   task automatic test_backpressure();
      idle_pct  = 0;
      stall_pct = 0;
      hold_cycles = 3000;
      for (int i = 0; i < 8; i++) send_decrypt(rand64(), rand64());
      drain();
   endtask

   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall   <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      rsp_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (plain_q.size() == 0) begin
            $error("unexpected result transaction %h", rsp_data);
            errors++;
         end else begin
            exp_r = plain_q.pop_front();
            n_checked++;
            if (rsp_data.plain_high !== exp_r.plain_high) begin
               $error("plain_high expected %h actual %h", exp_r.plain_high, rsp_data.plain_high);
               errors++;
            end
            if (rsp_data.plain_low !== exp_r.plain_low) begin
               $error("plain_low expected %h actual %h", exp_r.plain_low, rsp_data.plain_low);
               errors++;
            end
         end
      end
   end

   initial begin
      #80_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_we      = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      rsp_stall   = 1'b0;
      hold_cycles = 0;
      idle_pct    = 0;
      stall_pct   = 0;
      errors      = 0;
      n_loads     = 0;
      n_decrypts  = 0;
      n_checked   = 0;
      key_size_q  = '0;
      for (int i = 0; i < 4; i++) key_q[i] = '0;
      repeat (8) @(negedge clock);
      reset = 1'b0;
      test_full_table_load();
      test_directed_decrypt();
      test_random_traffic(200, 0, 0);
      test_random_traffic(200, 77, 0);
      test_random_traffic(200, 0, 77);
      test_random_traffic(200, 14, 14);
      test_backpressure();
      test_full_table_load();
      test_random_traffic(200, 30, 30);
      if (plain_q.size() != 0) begin
         $error("%0d expected results never arrived", plain_q.size());
         errors++;
      end
      $display("covered %0d S-box loads and %0d decrypts (%0d results checked)",
               n_loads, n_decrypts, n_checked);
      $display("all key sizes, table reloads, idle/stall mixes and a long output hold-off");
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
